@@ design/sptp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package sptp_pkg;

    typedef logic [1:0] t_status;

    localparam t_status ST_VALID     = 2'd0;
    localparam t_status ST_OPEN      = 2'd1;
    localparam t_status ST_OVERFLOW  = 2'd2;
    localparam t_status ST_UNDERFLOW = 2'd3;

    localparam int          CFG_IDX_W = 3;
    localparam int          CFG_DATA_W = 16;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_LEFT_MIN  = 3'd0;
    localparam t_cfg_idx CFG_LEFT_MAX  = 3'd1;
    localparam t_cfg_idx CFG_RIGHT_MIN = 3'd2;
    localparam t_cfg_idx CFG_RIGHT_MAX = 3'd3;
    localparam t_cfg_idx CFG_ZERO      = 3'd4;
    localparam t_cfg_idx CFG_GAP_RATIO = 3'd5;

    localparam logic [15:0] GAP_RATIO_RESET = 16'd6554;
    localparam logic [7:0]  POS_NONE = 8'd255;
    localparam logic [7:0]  POS_TOP  = 8'd254;

endpackage

`default_nettype wire

@@ design/sptp_ifs.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface sptp_in_if #(parameter int ADC_BITS = 10);
    logic                valid;
    logic                ready;
    logic [ADC_BITS-1:0] adc_left;
    logic [ADC_BITS-1:0] adc_right;
    modport source (output valid, adc_left, adc_right, input ready);
    modport sink   (input valid, adc_left, adc_right, output ready);
endinterface

interface sptp_out_if import sptp_pkg::*;;
    logic    valid;
    logic    ready;
    t_status left_status;
    t_status right_status;
    logic [7:0] first_position;
    logic [7:0] second_position;
    logic [7:0] gap_center;
    logic [7:0] gap_size;
    modport source (output valid, left_status, right_status, first_position,
                    second_position, gap_center, gap_size, input ready);
    modport sink   (input valid, left_status, right_status, first_position,
                    second_position, gap_center, gap_size, output ready);
endinterface

interface sptp_cfg_if import sptp_pkg::*;;
    logic                  valid;
    logic                  ready;
    t_cfg_idx              index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ design/sptp_div.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per register stage.
// Requires i_num[top DEN_W bits] < i_den for an exact quotient.
module sptp_div #(
    parameter int DEN_W = 10,
    parameter int Q_W   = 10,
    parameter int SB_W  = 2
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_en,
    input  wire logic                   i_vld,
    input  wire logic [DEN_W+Q_W-1:0]   i_num,
    input  wire logic [DEN_W-1:0]       i_den,
    input  wire logic [SB_W-1:0]        i_sb,
    output logic                        o_vld,
    output logic [Q_W-1:0]              o_q,
    output logic [SB_W-1:0]             o_sb
);

    logic [DEN_W-1:0] r_rem [Q_W];
    logic [Q_W-1:0]   r_low [Q_W];
    logic [DEN_W-1:0] r_den [Q_W];
    logic [SB_W-1:0]  r_sb  [Q_W];
    logic [Q_W-1:0]   r_vld;

    for (genvar k = 0; k < Q_W; k++) begin : g_stage
        logic [DEN_W-1:0] w_rem;
        logic [Q_W-1:0]   w_low;
        logic [DEN_W-1:0] w_den;
        logic [SB_W-1:0]  w_sb;
        logic             w_vld;
        logic [DEN_W:0]   w_t;
        logic [DEN_W:0]   w_diff;
        logic             w_ge;
        logic [DEN_W-1:0] n_rem;
        logic [Q_W-1:0]   n_low;

        if (k == 0) begin : g_first
            assign w_rem = i_num[DEN_W+Q_W-1:Q_W];
            assign w_low = i_num[Q_W-1:0];
            assign w_den = i_den;
            assign w_sb  = i_sb;
            assign w_vld = i_vld;
        end else begin : g_next
            assign w_rem = r_rem[k-1];
            assign w_low = r_low[k-1];
            assign w_den = r_den[k-1];
            assign w_sb  = r_sb[k-1];
            assign w_vld = r_vld[k-1];
        end

        assign w_t    = {w_rem, w_low[Q_W-1]};
        assign w_ge   = w_t >= {1'b0, w_den};
        assign w_diff = w_t - {1'b0, w_den};
        assign n_rem  = w_ge ? w_diff[DEN_W-1:0] : w_t[DEN_W-1:0];
        // shift the used numerator bit out, the quotient bit in
        assign n_low  = {w_low[Q_W-2:0], w_ge};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_rem;
                r_low[k] <= n_low;
                r_den[k] <= w_den;
                r_sb[k]  <= w_sb;
            end
        end
    end

    assign o_vld = r_vld[Q_W-1];
    assign o_q   = r_low[Q_W-1];
    assign o_sb  = r_sb[Q_W-1];

endmodule

`default_nettype wire

@@ design/dual_end_softpot_touch_position_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Dual-ended soft potentiometer touch position.
// i_in carries one pair of end samples per request; o_out returns one result
// per request: both side statuses, the left position, the gap-checked right
// position, and the gap center and size. i_cfg writes the six calibration
// registers by index; it is always ready and must only be used while idle.
// Throughput: one request per cycle while o_out is not stalled. The path
// to o_out.valid is the resistance divider (one stage per
// quotient bit, ADC_BITS stages) and the position divider (8 stages), plus
// three register stages around the multipliers and an output register.
// The whole pipeline advances together; when the receiver stalls with a
// result waiting, every stage holds and i_in.ready drops, so nothing is lost
// or repeated. Reset clears all valid bits and loads the calibration
// registers with zero and the gap ratio with 6554.
module dual_end_softpot_touch_position_core
    import sptp_pkg::*;
#(
    parameter int ADC_BITS = 10
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    sptp_in_if.sink     i_in,
    sptp_out_if.source  o_out,
    sptp_cfg_if.sink    i_cfg
);

    localparam int B = ADC_BITS;

    // calibration registers
    logic [B-1:0] r_lmin, r_lmax, r_rmin, r_rmax, r_zero;
    logic [15:0]  r_gap;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lmin <= '0;
            r_lmax <= '0;
            r_rmin <= '0;
            r_rmax <= '0;
            r_zero <= '0;
            r_gap  <= GAP_RATIO_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_LEFT_MIN:  r_lmin <= i_cfg.data[B-1:0];
                CFG_LEFT_MAX:  r_lmax <= i_cfg.data[B-1:0];
                CFG_RIGHT_MIN: r_rmin <= i_cfg.data[B-1:0];
                CFG_RIGHT_MAX: r_rmax <= i_cfg.data[B-1:0];
                CFG_ZERO:      r_zero <= i_cfg.data[B-1:0];
                CFG_GAP_RATIO: r_gap  <= i_cfg.data[15:0];
                default: ;
            endcase
        end
    end

    logic [B-1:0] w_lrange, w_rrange;
    assign w_lrange = (r_lmin > r_lmax) ? r_lmin - r_lmax : '0;
    assign w_rrange = (r_rmin > r_rmax) ? r_rmin - r_rmax : '0;

    function automatic t_status f_status(input logic [B-1:0] adc, input logic [B-1:0] mn,
                                         input logic [B-1:0] mx, input logic [B-1:0] zl);
        t_status st;
        if (mn == '0 || mx == '0 || adc <= zl) st = ST_OPEN;
        else if (adc < mx)                      st = ST_OVERFLOW;
        else if (adc > mn)                      st = ST_UNDERFLOW;
        else                                    st = ST_VALID;
        return st;
    endfunction

    function automatic logic [7:0] f_pos(input t_status st, input logic [7:0] q,
                                         input logic [B-1:0] range);
        logic [7:0] p;
        case (st)
            ST_OPEN:      p = POS_NONE;
            ST_OVERFLOW:  p = POS_TOP;
            ST_UNDERFLOW: p = 8'd0;
            default:      p = (range == '0) ? 8'd0 : q;
        endcase
        return p;
    endfunction

    logic r_out_vld;
    logic w_en;
    assign w_en = !r_out_vld || o_out.ready;
    assign i_in.ready = w_en;

    // stage 1: status and max*min products
    logic         r1_vld;
    t_status      r1_sl, r1_sr;
    logic [2*B-1:0] r1_pl, r1_pr;
    logic [B-1:0] r1_al, r1_ar;
    t_status      w_sl, w_sr;
    logic         w_both_low;

    assign w_both_low = (i_in.adc_left < r_lmax) && (i_in.adc_right < r_rmax);
    assign w_sl = w_both_low ? ST_OPEN : f_status(i_in.adc_left, r_lmin, r_lmax, r_zero);
    assign w_sr = w_both_low ? ST_OPEN : f_status(i_in.adc_right, r_rmin, r_rmax, r_zero);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (w_en) begin
            r1_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_sl <= w_sl;
            r1_sr <= w_sr;
            r1_pl <= {{B{1'b0}}, r_lmax} * {{B{1'b0}}, r_lmin};
            r1_pr <= {{B{1'b0}}, r_rmax} * {{B{1'b0}}, r_rmin};
            r1_al <= i_in.adc_left;
            r1_ar <= i_in.adc_right;
        end
    end

    // resistance dividers: max*min / adc
    logic         d1l_vld, d1r_vld;
    logic [B-1:0] d1_ql, d1_qr;
    t_status      d1_sl, d1_sr;

    sptp_div #(.DEN_W(B), .Q_W(B), .SB_W(2)) u_div_res_l (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_vld(r1_vld),
        .i_num(r1_pl), .i_den(r1_al), .i_sb(r1_sl),
        .o_vld(d1l_vld), .o_q(d1_ql), .o_sb(d1_sl)
    );

    sptp_div #(.DEN_W(B), .Q_W(B), .SB_W(2)) u_div_res_r (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_vld(r1_vld),
        .i_num(r1_pr), .i_den(r1_ar), .i_sb(r1_sr),
        .o_vld(d1r_vld), .o_q(d1_qr), .o_sb(d1_sr)
    );

    // stage 2: relative resistance, clamp, gap distance
    logic         r2_vld;
    t_status      r2_sl, r2_sr;
    logic [B-1:0] r2_xl, r2_xr;
    logic [B:0]   r2_dabs;
    logic [B-1:0] w_rl, w_rr, w_rlc, w_rrc;
    logic signed [B+1:0] w_d;

    assign w_rl  = (d1_sl == ST_VALID) ? d1_ql - r_lmax : '0;
    assign w_rr  = (d1_sr == ST_VALID) ? d1_qr - r_rmax : '0;
    assign w_rlc = (w_rl > w_lrange) ? w_lrange : w_rl;
    assign w_rrc = (w_rr > w_rrange) ? w_rrange : w_rr;
    assign w_d   = $signed({2'b00, w_rrange}) - $signed({2'b00, w_rr})
                 - $signed({2'b00, w_rl});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (w_en) begin
            r2_vld <= d1l_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_sl   <= d1_sl;
            r2_sr   <= d1_sr;
            r2_xl   <= w_rlc;
            r2_xr   <= w_rrange - w_rrc;
            r2_dabs <= w_d[B+1] ? (B+1)'(0) - w_d[B:0] : w_d[B:0];
        end
    end

    // stage 3: scale to position range, gap threshold product
    logic          r3_vld;
    t_status       r3_sl, r3_sr;
    logic [B:0]    r3_dabs;
    logic [B+7:0]  r3_nl, r3_nr;
    logic [B+15:0] r3_gprod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (w_en) begin
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_sl    <= r2_sl;
            r3_sr    <= r2_sr;
            r3_dabs  <= r2_dabs;
            r3_nl    <= {8'd0, r2_xl} * (B+8)'(POS_TOP);
            r3_nr    <= {8'd0, r2_xr} * (B+8)'(POS_TOP);
            r3_gprod <= {{B{1'b0}}, r_gap} * {16'd0, w_rrange};
        end
    end

    // position dividers: x*254 / range
    localparam int SB2_W = 2 + (B + 1) + (B + 16);
    logic             d2l_vld, d2r_vld;
    logic [7:0]       d2_ql, d2_qr;
    logic [SB2_W-1:0] d2_sbl;
    t_status          d2_sr, d2_sl;
    logic [B:0]       d2_dabs;
    logic [B+15:0]    d2_gprod;

    sptp_div #(.DEN_W(B), .Q_W(8), .SB_W(SB2_W)) u_div_pos_l (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_vld(r3_vld),
        .i_num(r3_nl), .i_den(w_lrange), .i_sb({r3_sl, r3_dabs, r3_gprod}),
        .o_vld(d2l_vld), .o_q(d2_ql), .o_sb(d2_sbl)
    );

    sptp_div #(.DEN_W(B), .Q_W(8), .SB_W(2)) u_div_pos_r (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_vld(r3_vld),
        .i_num(r3_nr), .i_den(w_rrange), .i_sb(r3_sr),
        .o_vld(d2r_vld), .o_q(d2_qr), .o_sb(d2_sr)
    );

    assign {d2_sl, d2_dabs, d2_gprod} = d2_sbl;

    // output stage: threshold = gprod / 65535, gap rule, center and size
    logic [B-1:0] w_q0;
    logic [17:0]  w_s, w_thr;
    logic [7:0]   w_p1, w_p2, w_p2s, w_size;
    logic [8:0]   w_sum;
    logic         w_float;

    assign w_q0  = d2_gprod[B+15:16];
    assign w_s   = 18'(w_q0) + 18'(d2_gprod[15:0]);
    assign w_thr = 18'(w_q0) + ((w_s >= 18'd131070) ? 18'd2 :
                                (w_s >= 18'd65535)  ? 18'd1 : 18'd0);
    assign w_p1  = f_pos(d2_sl, d2_ql, w_lrange);
    assign w_p2  = f_pos(d2_sr, d2_qr, w_rrange);
    assign w_p2s = (d2_sl == ST_VALID && d2_sr == ST_VALID && 18'(d2_dabs) < w_thr)
                 ? POS_NONE : w_p2;
    assign w_float = (w_p1 == POS_NONE) || (w_p2 == POS_NONE);
    assign w_sum   = {1'b0, w_p1} + {1'b0, w_p2};
    assign w_size  = (w_p1 > w_p2) ? w_p1 - w_p2 : w_p2 - w_p1;

    t_status    r_out_sl, r_out_sr;
    logic [7:0] r_out_p1, r_out_p2, r_out_center, r_out_size;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= d2l_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_sl     <= d2_sl;
            r_out_sr     <= d2_sr;
            r_out_p1     <= w_p1;
            r_out_p2     <= w_p2s;
            r_out_center <= w_float ? POS_NONE : w_sum[8:1];
            r_out_size   <= w_float ? POS_NONE : w_size;
        end
    end

    assign o_out.valid           = r_out_vld;
    assign o_out.left_status     = r_out_sl;
    assign o_out.right_status    = r_out_sr;
    assign o_out.first_position  = r_out_p1;
    assign o_out.second_position = r_out_p2;
    assign o_out.gap_center      = r_out_center;
    assign o_out.gap_size        = r_out_size;

    a_lanes_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (d1l_vld == d1r_vld) && (d2l_vld == d2r_vld))
        else $error("divider lanes out of step");

    a_open_no_touch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.left_status == ST_OPEN |-> o_out.first_position == POS_NONE)
        else $error("open left side reports a position");

    a_float_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.first_position == POS_NONE
        |-> o_out.gap_center == POS_NONE && o_out.gap_size == POS_NONE)
        else $error("gap reported without a left touch");

    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !o_out.valid)
        else $error("result valid after reset");

endmodule

`default_nettype wire

@@ tb/dual_end_softpot_touch_position_core_test.sv @@
`timescale 1ns / 1ps

module dual_end_softpot_touch_position_core_test;
    import sptp_pkg::*;

    localparam int ADC_BITS = 10;
    localparam int LATENCY = ADC_BITS + 12;

    typedef struct packed {
        logic [ADC_BITS-1:0] adc_left;
        logic [ADC_BITS-1:0] adc_right;
    } t_sample;

    typedef struct packed {
        t_status    left_status;
        t_status    right_status;
        logic [7:0] first_position;
        logic [7:0] second_position;
        logic [7:0] gap_center;
        logic [7:0] gap_size;
    } t_touch;

    logic i_clk;
    logic i_rst_n;

    sptp_in_if #(.ADC_BITS(ADC_BITS)) in_ch ();
    sptp_out_if out_ch ();
    sptp_cfg_if cfg_ch ();

    dual_end_softpot_touch_position_core #(.ADC_BITS(ADC_BITS)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    // calibration copy used by the predictor
    int unsigned cal_lmin, cal_lmax, cal_rmin, cal_rmax, cal_zero, cal_ratio;

    t_sample sample_queue[$];
    t_touch  touch_queue[$];
    int      mismatches;
    bit      hold_sender;
    int      burst_left;
    int      gap_left;
    int      stall_phase;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #100ms;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic t_status eval_side(int unsigned adc, int unsigned mn, int unsigned mx,
                                          output int unsigned res);
        res = 0;
        if (mn == 0 || mx == 0 || adc <= cal_zero) return ST_OPEN;
        if (adc < mx) return ST_OVERFLOW;
        if (adc > mn) return ST_UNDERFLOW;
        res = (mx * mn) / adc - mx;
        return ST_VALID;
    endfunction

    function automatic int unsigned map_side(t_status st, int unsigned res, int unsigned mn,
                                             int unsigned mx, bit invert);
        int unsigned range;
        int unsigned x;
        if (st == ST_OPEN) return POS_NONE;
        if (st == ST_OVERFLOW) return POS_TOP;
        if (st == ST_UNDERFLOW) return 0;
        if (mn <= mx) return 0;
        range = mn - mx;
        if (res > range) res = range;
        x = invert ? range - res : res;
        return (x * POS_TOP) / range;
    endfunction

    function automatic t_touch predict_touch(t_sample s);
        t_touch      t;
        t_status     sl, sr;
        int unsigned rl, rr, p1, p2, rrange, thr;
        longint      d;
        rl = 0;
        rr = 0;
        if (s.adc_left < cal_lmax && s.adc_right < cal_rmax) begin
            sl = ST_OPEN;
            sr = ST_OPEN;
        end else begin
            sl = eval_side(s.adc_left, cal_lmin, cal_lmax, rl);
            sr = eval_side(s.adc_right, cal_rmin, cal_rmax, rr);
        end
        p1 = map_side(sl, rl, cal_lmin, cal_lmax, 1'b0);
        p2 = map_side(sr, rr, cal_rmin, cal_rmax, 1'b1);
        rrange = cal_rmin > cal_rmax ? cal_rmin - cal_rmax : 0;
        thr = 32'((longint'(cal_ratio) * rrange) / 65535);
        t.left_status = sl;
        t.right_status = sr;
        t.first_position = p1[7:0];
        t.second_position = p2[7:0];
        if (sl == ST_VALID && sr == ST_VALID) begin
            d = longint'(rrange) - longint'(rr) - longint'(rl);
            if (d < 0) d = -d;
            if (d < thr) t.second_position = POS_NONE;
        end
        if (p1 != POS_NONE && p2 != POS_NONE) begin
            t.gap_center = 8'((p1 + p2) / 2);
            t.gap_size = 8'(p1 > p2 ? p1 - p2 : p2 - p1);
        end else begin
            t.gap_center = POS_NONE;
            t.gap_size = POS_NONE;
        end
        return t;
    endfunction

    // driver: bursts and gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            in_ch.adc_left <= '0;
            in_ch.adc_right <= '0;
            burst_left <= 0;
            gap_left <= 0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                touch_queue.push_back(predict_touch({in_ch.adc_left, in_ch.adc_right}));
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    in_ch.valid <= 1'b0;
                end else if (sample_queue.size() > 0 && !hold_sender) begin
                    {in_ch.adc_left, in_ch.adc_right} <= sample_queue.pop_front();
                    in_ch.valid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // monitor with its own stall pattern
    always @(posedge i_clk) begin
        t_touch got;
        t_touch want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            stall_phase <= 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                got = {out_ch.left_status, out_ch.right_status, out_ch.first_position,
                       out_ch.second_position, out_ch.gap_center, out_ch.gap_size};
                if (touch_queue.size() == 0) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10) $display("unexpected result %h", got);
                end else begin
                    want = touch_queue.pop_front();
                    if (got !== want) begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display("mismatch: expected %h actual %h", want, got);
                    end
                end
            end
            stall_phase <= (stall_phase + 1) % 97;
            if (stall_phase < 30) out_ch.ready <= 1'b1;
            else if (stall_phase < 50) out_ch.ready <= ($urandom_range(0, 3) != 0);
            else out_ch.ready <= ($urandom_range(0, 2) == 0);
        end
    end

    // leaves valid high; the caller drops it after the last write
    task automatic write_reg(t_cfg_idx idx, int unsigned value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= value[CFG_DATA_W-1:0];
        do @(posedge i_clk); while (!cfg_ch.ready);
        case (idx)
            CFG_LEFT_MIN:  cal_lmin = value & 10'h3ff;
            CFG_LEFT_MAX:  cal_lmax = value & 10'h3ff;
            CFG_RIGHT_MIN: cal_rmin = value & 10'h3ff;
            CFG_RIGHT_MAX: cal_rmax = value & 10'h3ff;
            CFG_ZERO:      cal_zero = value & 10'h3ff;
            default:       cal_ratio = value & 16'hffff;
        endcase
    endtask

    task automatic drain();
        while (sample_queue.size() > 0 || in_ch.valid || touch_queue.size() > 0)
            @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic calibrate(int unsigned lmin, int unsigned lmax, int unsigned rmin,
                             int unsigned rmax, int unsigned zero, int unsigned ratio);
        write_reg(CFG_LEFT_MIN, lmin);
        write_reg(CFG_LEFT_MAX, lmax);
        write_reg(CFG_RIGHT_MIN, rmin);
        write_reg(CFG_RIGHT_MAX, rmax);
        write_reg(CFG_ZERO, zero);
        write_reg(CFG_GAP_RATIO, ratio);
        cfg_ch.valid <= 1'b0;
    endtask

    // mostly samples inside the calibrated window, some anywhere
    task automatic queue_random(int count);
        int unsigned l, r;
        repeat (count) begin
            if ($urandom_range(0, 3) != 0 && cal_lmin > cal_lmax && cal_rmin > cal_rmax) begin
                l = $urandom_range(cal_lmax, cal_lmin);
                r = $urandom_range(cal_rmax, cal_rmin);
            end else begin
                l = $urandom_range(0, 1023);
                r = $urandom_range(0, 1023);
            end
            sample_queue.push_back({l[ADC_BITS-1:0], r[ADC_BITS-1:0]});
        end
    endtask

    initial begin
        in_ch.valid = 1'b0;
        in_ch.adc_left = '0;
        in_ch.adc_right = '0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CFG_LEFT_MIN;
        cfg_ch.data = '0;
        mismatches = 0;
        hold_sender = 1'b0;
        cal_lmin = 0; cal_lmax = 0; cal_rmin = 0; cal_rmax = 0; cal_zero = 0;
        cal_ratio = GAP_RATIO_RESET;
        i_rst_n = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // uncalibrated: every side open
        sample_queue.push_back({10'd0, 10'd0});
        sample_queue.push_back({10'h3ff, 10'h3ff});
        queue_random(3);
        drain();

        calibrate(900, 100, 950, 80, 20, 6554);
        sample_queue.push_back({10'd50, 10'd50});
        sample_queue.push_back({10'd10, 10'd500});
        sample_queue.push_back({10'd20, 10'd21});
        sample_queue.push_back({10'd99, 10'd500});
        sample_queue.push_back({10'd901, 10'd951});
        sample_queue.push_back({10'd100, 10'd80});
        sample_queue.push_back({10'd900, 10'd950});
        sample_queue.push_back({10'd300, 10'd300});
        sample_queue.push_back({10'h3ff, 10'h2aa});
        sample_queue.push_back({10'h155, 10'h3ff});
        drain();

        // empty ranges and unusual extremes
        calibrate(100, 100, 50, 60, 0, 65535);
        sample_queue.push_back({10'd100, 10'd55});
        sample_queue.push_back({10'd100, 10'd60});
        sample_queue.push_back({10'd0, 10'h3ff});
        queue_random(100);
        drain();

        calibrate(1023, 1, 1023, 1, 1023, 0);
        sample_queue.push_back({10'h3ff, 10'h3ff});
        queue_random(50);
        drain();

        calibrate(1023, 1, 1023, 1, 0, 0);
        queue_random(200);
        drain();

        calibrate(800, 200, 700, 150, 100, 65535);
        queue_random(150);
        // let part of the queue go out, pause until the pipeline is empty, then resume
        while (sample_queue.size() > 75) @(posedge i_clk);
        hold_sender = 1'b1;
        while (in_ch.valid || touch_queue.size() > 0) @(posedge i_clk);
        hold_sender = 1'b0;
        queue_random(150);
        drain();

        repeat (5) begin
            calibrate($urandom_range(0, 1023), $urandom_range(0, 1023),
                      $urandom_range(0, 1023), $urandom_range(0, 1023),
                      $urandom_range(0, 60), $urandom_range(0, 65535));
            queue_random(100);
            drain();
        end

        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
